### hw/rtl/vat_pkg.sv
// vat_pkg: shared types and constants of the vertex affine transform
// no dependencies; used by the interfaces, vat_dot and the top level
`default_nettype none

package vat_pkg;

    localparam int FIELD_BITS = 16;
    localparam int SLOT_BITS  = 16;
    localparam int NUM_SLOTS  = 4;
    localparam int COL_BITS   = SLOT_BITS * NUM_SLOTS;
    localparam int FRAC_COEFF = 12;
    localparam int PROD_BITS  = 2 * FIELD_BITS;
    localparam int ACC_BITS   = PROD_BITS + 4;
    localparam int CFG_IDX_BITS = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_X_COL = 2'd0,
        REG_Y_COL = 2'd1,
        REG_Z_COL = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_pipe_en;

    localparam logic [COL_BITS-1:0] X_COL_RST = 64'h0000_0000_0000_1000;
    localparam logic [COL_BITS-1:0] Y_COL_RST = 64'h0000_0000_1000_0000;
    localparam logic [COL_BITS-1:0] Z_COL_RST = 64'h0000_1000_0000_0000;

endpackage

`default_nettype wire

### hw/rtl/vat_vertex_if.sv
// vat_vertex_if: input channel, one vertex word (position and normal, Q8.8)
// depends on vat_pkg
`default_nettype none

interface vat_vertex_if
    import vat_pkg::*;
;
    logic                           valid;
    logic                           ready;
    logic signed [FIELD_BITS-1:0]   pos_x;
    logic signed [FIELD_BITS-1:0]   pos_y;
    logic signed [FIELD_BITS-1:0]   pos_z;
    logic signed [FIELD_BITS-1:0]   norm_x;
    logic signed [FIELD_BITS-1:0]   norm_y;
    logic signed [FIELD_BITS-1:0]   norm_z;

    modport source (
        output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
        input  ready
    );

    modport sink (
        input  valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
        output ready
    );
endinterface

`default_nettype wire

### hw/rtl/vat_result_if.sv
// vat_result_if: output channel, one transformed vertex word with clip flag
// depends on vat_pkg
`default_nettype none

interface vat_result_if
    import vat_pkg::*;
;
    logic                           valid;
    logic                           ready;
    logic signed [FIELD_BITS-1:0]   out_pos_x;
    logic signed [FIELD_BITS-1:0]   out_pos_y;
    logic signed [FIELD_BITS-1:0]   out_pos_z;
    logic signed [FIELD_BITS-1:0]   out_norm_x;
    logic signed [FIELD_BITS-1:0]   out_norm_y;
    logic signed [FIELD_BITS-1:0]   out_norm_z;
    logic                           clipped;

    modport source (
        output valid, out_pos_x, out_pos_y, out_pos_z,
               out_norm_x, out_norm_y, out_norm_z, clipped,
        input  ready
    );

    modport sink (
        input  valid, out_pos_x, out_pos_y, out_pos_z,
               out_norm_x, out_norm_y, out_norm_z, clipped,
        output ready
    );
endinterface

`default_nettype wire

### hw/rtl/vat_dot.sv
// vat_dot: three-stage dot product of one vector with one matrix column,
// optional translation, round to nearest and saturation; depends on vat_pkg
`default_nettype none

module vat_dot
    import vat_pkg::*;
#(
    parameter int  COORD_W    = 16,
    parameter int  COEFF_W    = 16,
    parameter bit  WITH_SHIFT = 1'b1
) (
    input  wire logic                                   i_clk,
    input  wire t_pipe_en                               i_en,
    input  wire logic [2:0][FIELD_BITS-1:0]             i_coord,
    input  wire logic [COL_BITS-1:0]                    i_col,
    output logic signed [FIELD_BITS-1:0]                o_value,
    output logic                                        o_clip
);

    localparam int CSH      = FIELD_BITS - COORD_W;
    localparam int KSH      = SLOT_BITS - COEFF_W;
    localparam int RES_BITS = ACC_BITS - FRAC_COEFF;
    localparam int SAT_HI_I = (1 << (COORD_W - 1)) - 1;
    localparam logic signed [RES_BITS-1:0] SAT_HI = RES_BITS'(SAT_HI_I);
    localparam logic signed [RES_BITS-1:0] SAT_LO = -SAT_HI - RES_BITS'(1);
    localparam logic signed [ACC_BITS-1:0] RND    = ACC_BITS'(1 << (FRAC_COEFF - 1));

    logic signed [FIELD_BITS-1:0] w_crd  [3];
    logic signed [SLOT_BITS-1:0]  w_cf   [3];
    logic signed [PROD_BITS-1:0]  n_prod [3];
    logic signed [PROD_BITS-1:0]  r_prod [3];
    logic signed [SLOT_BITS-1:0]  n_shift;
    logic signed [SLOT_BITS-1:0]  r_shift;
    logic signed [ACC_BITS-1:0]   n_acc;
    logic signed [ACC_BITS-1:0]   r_acc;
    logic signed [RES_BITS-1:0]   w_res;
    logic signed [FIELD_BITS-1:0] n_value;
    logic                         n_clip;
    logic signed [FIELD_BITS-1:0] r_value;
    logic                         r_clip;

    // sign extension from the configured widths, then the products
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_crd[k]  = $signed(i_coord[k] << CSH) >>> CSH;
            w_cf[k]   = $signed(i_col[k*SLOT_BITS +: SLOT_BITS] << KSH) >>> KSH;
            n_prod[k] = PROD_BITS'(w_crd[k] * w_cf[k]);
        end
        n_shift = WITH_SHIFT ? $signed(i_col[3*SLOT_BITS +: SLOT_BITS])
                             : '0;
    end

    always_comb begin
        n_acc = ACC_BITS'(r_prod[0]) + ACC_BITS'(r_prod[1]) + ACC_BITS'(r_prod[2])
              + (ACC_BITS'(r_shift) <<< FRAC_COEFF) + RND;
    end

    // floor shift, then clamp to the coordinate range
    always_comb begin
        w_res = r_acc[ACC_BITS-1:FRAC_COEFF];
        if (w_res > SAT_HI) begin
            n_value = FIELD_BITS'(SAT_HI);
            n_clip  = 1'b1;
        end else if (w_res < SAT_LO) begin
            n_value = FIELD_BITS'(SAT_LO);
            n_clip  = 1'b1;
        end else begin
            n_value = FIELD_BITS'(w_res);
            n_clip  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_prod  <= n_prod;
            r_shift <= n_shift;
        end
        if (i_en.s2) begin
            r_acc <= n_acc;
        end
        if (i_en.s3) begin
            r_value <= n_value;
            r_clip  <= n_clip;
        end
    end

    assign o_value = r_value;
    assign o_clip  = r_clip;

endmodule

`default_nettype wire

### hw/rtl/vertex_affine_transform_top.sv
// vertex_affine_transform_top: 4x3 affine transform of position and normal
// depends on vat_pkg, vat_vertex_if, vat_result_if and vat_dot
//
// i_vtx carries one vertex word (position and normal, signed Q8.8) per
// valid/ready handshake; o_res returns one word per vertex: the position
// times the linear part plus translation, the normal times the linear part,
// both rounded to nearest and saturated, and a clip flag.
// the three column registers are written through i_cfg_we / i_cfg_idx /
// i_cfg_data; the user must write them only while no vertex is in flight,
// which the block does not enforce; index 3 is ignored. vertices flow
// through the three-stage multiply, sum and saturate pipeline, one per
// cycle while o_res does not stall, six column units working in parallel.
// a stalled o_res holds its word; earlier stages keep filling until every
// stage is full, and only then does i_vtx.ready drop.
// reset empties the pipeline and loads the identity matrix, no translation.
`default_nettype none

module vertex_affine_transform_top
    import vat_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int COEFF_BITS = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    vat_vertex_if.sink                      i_vtx,
    vat_result_if.source                    o_res,
    input  wire logic                       i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  wire logic [COL_BITS-1:0]        i_cfg_data
);

    localparam int COORD_W = (COORD_BITS > FIELD_BITS) ? FIELD_BITS : COORD_BITS;
    localparam int COEFF_W = (COEFF_BITS > SLOT_BITS) ? SLOT_BITS : COEFF_BITS;

    logic [COL_BITS-1:0] r_col [3];
    logic                r_v1;
    logic                r_v2;
    logic                r_v3;
    t_pipe_en            w_en;
    logic [2:0][FIELD_BITS-1:0] w_pos;
    logic [2:0][FIELD_BITS-1:0] w_nrm;
    logic signed [FIELD_BITS-1:0] w_val  [6];
    logic [5:0]          w_clip;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col[0] <= X_COL_RST;
            r_col[1] <= Y_COL_RST;
            r_col[2] <= Z_COL_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_X_COL: r_col[0] <= i_cfg_data;
                REG_Y_COL: r_col[1] <= i_cfg_data;
                REG_Z_COL: r_col[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // per-stage advance, bubbles are squeezed out under stall
    always_comb begin
        w_en.s3 = !r_v3 || o_res.ready;
        w_en.s2 = !r_v2 || w_en.s3;
        w_en.s1 = !r_v1 || w_en.s2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en.s1) begin
                r_v1 <= i_vtx.valid;
            end
            if (w_en.s2) begin
                r_v2 <= r_v1;
            end
            if (w_en.s3) begin
                r_v3 <= r_v2;
            end
        end
    end

    assign i_vtx.ready = i_rst_n && w_en.s1;

    assign w_pos = {i_vtx.pos_z, i_vtx.pos_y, i_vtx.pos_x};
    assign w_nrm = {i_vtx.norm_z, i_vtx.norm_y, i_vtx.norm_x};

    for (genvar c = 0; c < 3; c++) begin : g_col
        vat_dot #(
            .COORD_W    (COORD_W),
            .COEFF_W    (COEFF_W),
            .WITH_SHIFT (1'b1)
        ) u_pos (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_coord (w_pos),
            .i_col   (r_col[c]),
            .o_value (w_val[c]),
            .o_clip  (w_clip[c])
        );

        vat_dot #(
            .COORD_W    (COORD_W),
            .COEFF_W    (COEFF_W),
            .WITH_SHIFT (1'b0)
        ) u_nrm (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_coord (w_nrm),
            .i_col   (r_col[c]),
            .o_value (w_val[c+3]),
            .o_clip  (w_clip[c+3])
        );
    end

    assign o_res.valid      = r_v3;
    assign o_res.out_pos_x  = w_val[0];
    assign o_res.out_pos_y  = w_val[1];
    assign o_res.out_pos_z  = w_val[2];
    assign o_res.out_norm_x = w_val[3];
    assign o_res.out_norm_y = w_val[4];
    assign o_res.out_norm_z = w_val[5];
    assign o_res.clipped    = |w_clip;

endmodule

`default_nettype wire
